// ===== hw/rtl/ppenc_pkg.sv =====
// ----------------------------------------------------------------------------
// Pre-transformed polar encoder package
// Shared sizes, command and register codes, and the butterfly function.
// ----------------------------------------------------------------------------
package ppenc_pkg;

   localparam int CODE_LENGTH = 64;        // supported range 2 to 64
   localparam int CW_W        = 64;        // width of message and codeword ports
   localparam int IDX_W       = 6;         // index into a 64-bit word
   localparam int ROWS        = 64;        // entries of the row store
   localparam int CSR_ADDR_W  = 4;
   localparam int CSR_DATA_W  = 64;

   localparam logic [CW_W-1:0] LENGTH_MASK =
      (CODE_LENGTH >= CW_W) ? {CW_W{1'b1}} : ((CW_W'(1) << CODE_LENGTH) - CW_W'(1));

   typedef enum logic {
      CMD_LOAD   = 1'b0,
      CMD_ENCODE = 1'b1
   } cmd_type;

   typedef enum logic {
      REG_FROZEN  = 1'b0,
      REG_DYNAMIC = 1'b1
   } reg_type;

   // Number of unfrozen positions below pos: the message bit that pos takes.
   function automatic logic [IDX_W-1:0] info_index(input logic [CW_W-1:0] frozen,
                                                   input int unsigned pos);
      logic [CW_W-1:0] below;
      below = (CW_W'(1) << pos) - CW_W'(1);
      return IDX_W'($countones(~frozen & below));
   endfunction

   // Natural-order polar transform, one stage per halving of the block size.
   function automatic logic [CW_W-1:0] butterfly(input logic [CW_W-1:0] u);
      logic [CW_W-1:0] v;
      v = u;
      for (int h = CODE_LENGTH >> 1; h > 0; h = h >> 1) begin
         for (int j = 0; j < CODE_LENGTH; j = j + 2 * h) begin
            for (int i = 0; i < h; i++) begin
               if ((j + i + h) < CW_W) begin
                  v[j + i] = v[j + i] ^ v[j + i + h];
               end
            end
         end
      end
      return v & LENGTH_MASK;
   endfunction

endpackage

// ===== hw/rtl/pretransformed_polar_encoder_top.sv =====
// ----------------------------------------------------------------------------
// Pre-transformed polar encoder, top level
// Encodes one frame per encode beat with dynamic frozen bits; load beats
// write one pre-transform row.
// ----------------------------------------------------------------------------
// Latency: an encode beat accepted at one rising edge shows its codeword on
// rsp_codeword, with rsp_valid high, for one cycle starting at the next edge.
// Throughput: one beat per cycle; busy is never raised and the receiver
// cannot stall, so the input and result registers never hold back.
// Reset (synchronous, active high) clears the masks, the row valid bits and
// all valid flags; no clearing pass is needed.
module pretransformed_polar_encoder_top (
   input  logic                              clock,
   input  logic                              reset,
   // command channel
   input  logic                              start,
   output logic                              busy,
   input  logic                              req_cmd,
   input  logic [ppenc_pkg::IDX_W-1:0]       req_row_index,
   input  logic [ppenc_pkg::CW_W-1:0]        req_row_mask,
   input  logic [ppenc_pkg::CW_W-1:0]        req_message,
   // result channel
   output logic                              rsp_valid,
   output logic [ppenc_pkg::CW_W-1:0]        rsp_codeword,
   // configuration port
   input  logic                              psel,
   input  logic                              penable,
   input  logic                              pwrite,
   input  logic [ppenc_pkg::CSR_ADDR_W-1:0]  paddr,
   input  logic [ppenc_pkg::CSR_DATA_W-1:0]  pwdata,
   output logic [ppenc_pkg::CSR_DATA_W-1:0]  prdata,
   output logic                              pready
);
   import ppenc_pkg::*;

   // ------------------------------------------------------------------------
   // Configuration registers. The registers sit 8 bytes apart, so address
   // bit 3 selects between the frozen mask and the dynamic mask.
   // ------------------------------------------------------------------------
   logic [CW_W-1:0] frozen_ff, frozen_in;
   logic [CW_W-1:0] dynamic_ff, dynamic_in;
   logic            csr_write;
   reg_type         csr_sel;

   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && pready;
   assign csr_sel   = reg_type'(paddr[3]);

   always_comb begin
      frozen_in  = frozen_ff;
      dynamic_in = dynamic_ff;
      if (csr_write) begin
         case (csr_sel)
            REG_FROZEN:  frozen_in  = pwdata;
            REG_DYNAMIC: dynamic_in = pwdata;
            default:     frozen_in  = frozen_ff;
         endcase
      end
   end

   always_comb begin
      case (csr_sel)
         REG_FROZEN:  prdata = frozen_ff;
         REG_DYNAMIC: prdata = dynamic_ff;
         default:     prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         frozen_ff  <= '0;
         dynamic_ff <= '0;
      end else begin
         frozen_ff  <= frozen_in;
         dynamic_ff <= dynamic_in;
      end
   end

   // ------------------------------------------------------------------------
   // Message-bit map. For each position, the index of the message bit it
   // takes if it is unfrozen. It depends only on the frozen mask, so it is
   // registered from frozen_ff after a configuration write; an encode beat
   // accepted at the edge after the write is evaluated in the cycle that
   // follows, when the map has already caught up.
   // ------------------------------------------------------------------------
   logic [IDX_W-1:0] idx_map_ff [CW_W];
   logic [IDX_W-1:0] idx_map_in [CW_W];

   always_comb begin
      for (int i = 0; i < CW_W; i++) begin
         idx_map_in[i] = info_index(frozen_ff, i);
      end
   end

   always_ff @(posedge clock) begin
      idx_map_ff <= idx_map_in;
   end

   // ------------------------------------------------------------------------
   // Input register. Busy is never raised, so every start is a beat.
   // ------------------------------------------------------------------------
   logic             req_accept;
   logic             req_valid_ff;
   cmd_type          req_cmd_ff;
   logic [IDX_W-1:0] req_row_index_ff;
   logic [CW_W-1:0]  req_row_mask_ff;
   logic [CW_W-1:0]  req_message_ff;

   assign busy       = 1'b0;
   assign req_accept = start && !busy;

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
      end else begin
         req_valid_ff <= req_accept;
      end
      req_cmd_ff       <= cmd_type'(req_cmd);
      req_row_index_ff <= req_row_index;
      req_row_mask_ff  <= req_row_mask;
      req_message_ff   <= req_message;
   end

   // ------------------------------------------------------------------------
   // Pre-transform row store. Each row is read at its own fixed position by
   // the parity logic, so it lives in flip-flops. A row whose valid bit is
   // clear reads as zero, which gives the all-zero reset contents without
   // clearing the row data itself. A load beat writes its row at the end of
   // its cycle in the input register, so an encode beat right behind it
   // sees the new row.
   // ------------------------------------------------------------------------
   logic [CW_W-1:0] rows_ff [ROWS];
   logic [ROWS-1:0] row_valid_ff;
   logic            row_write;

   assign row_write = req_valid_ff && (req_cmd_ff == CMD_LOAD);

   always_ff @(posedge clock) begin
      if (reset) begin
         row_valid_ff <= '0;
      end else if (row_write) begin
         row_valid_ff[req_row_index_ff] <= 1'b1;
      end
      if (row_write) begin
         rows_ff[req_row_index_ff] <= req_row_mask_ff;
      end
   end

   // ------------------------------------------------------------------------
   // Vector build. An unfrozen position takes its mapped message bit; a
   // frozen position is zero unless it is dynamic, when it takes the parity
   // of the message bits its row selects. Positions past the code length
   // stay zero.
   // ------------------------------------------------------------------------
   logic [CW_W-1:0] u_in;

   always_comb begin
      u_in = '0;
      for (int i = 0; i < CW_W; i++) begin
         if (i < CODE_LENGTH) begin
            if (frozen_ff[i]) begin
               u_in[i] = dynamic_ff[i] && row_valid_ff[i]
                         && (^(req_message_ff & rows_ff[i]));
            end else begin
               u_in[i] = req_message_ff[idx_map_ff[i]];
            end
         end
      end
   end

   // ------------------------------------------------------------------------
   // Butterfly into the result register, straight from the vector build.
   // The result is shown for exactly one cycle; the receiver has to take it
   // then.
   // ------------------------------------------------------------------------
   logic            rsp_valid_ff;
   logic [CW_W-1:0] rsp_codeword_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= req_valid_ff && (req_cmd_ff == CMD_ENCODE);
      end
      rsp_codeword_ff <= butterfly(u_in);
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_codeword = rsp_codeword_ff;

endmodule

// ===== hw/rtl/ppenc_checker.sv =====
// ----------------------------------------------------------------------------
// Pre-transformed polar encoder port checker
// Checks latency and result behaviour seen on the top-level ports.
// ----------------------------------------------------------------------------
module ppenc_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              start,
   input logic                              busy,
   input logic                              req_cmd,
   input logic                              rsp_valid,
   input logic [ppenc_pkg::CW_W-1:0]        rsp_codeword,
   input logic                              psel,
   input logic                              penable,
   input logic                              pwrite,
   input logic [ppenc_pkg::CSR_ADDR_W-1:0]  paddr,
   input logic [ppenc_pkg::CSR_DATA_W-1:0]  pwdata,
   input logic [ppenc_pkg::CSR_DATA_W-1:0]  prdata
);
   import ppenc_pkg::*;

   // Every encode beat gives a codeword, through the input and result registers.
   a_encode_latency: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && (req_cmd == CMD_ENCODE)) |-> ##2 rsp_valid)
      else $error("encode beat gave no result at the expected cycle");

   // A load beat gives no result.
   a_load_silent: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && (req_cmd == CMD_LOAD)) |-> ##2 !rsp_valid)
      else $error("load beat gave a result");

   // No result appears straight after reset.
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result strobe after reset");

   // A written mask reads back at the same address in the next cycle.
   a_csr_readback: assert property (@(posedge clock) disable iff (reset)
      (psel && penable && pwrite) ##1 (paddr[3] == $past(paddr[3]))
      |-> (prdata == $past(pwdata)))
      else $error("configuration register read back wrong");

   // Codeword bits at and above the code length are zero.
   a_length: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((rsp_codeword & ~LENGTH_MASK) == '0))
      else $error("codeword bits beyond the code length set");

endmodule

bind pretransformed_polar_encoder_top ppenc_checker u_ppenc_checker (.*);
